FILE: src/assert_macros.svh
// assertion helpers, clocked on clk and disabled while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent true implies consequent true in the same cycle
`define NVL2S_ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent true implies consequent true in the next cycle
`define NVL2S_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/nvl2s_pkg.sv
// ----------------------------------------------------------------------------
// nvl2s_pkg
// Shared constants, types and codes for the nearest-vector L2 search block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package nvl2s_pkg;

	localparam int MAX_REPS   = 1024;
	localparam int MAX_DIMS   = 64;
	localparam int ELEM_WIDTH = 16;

	localparam int REP_IDX_W  = $clog2(MAX_REPS);
	localparam int DIM_IDX_W  = $clog2(MAX_DIMS);
	localparam int REP_CNT_W  = REP_IDX_W + 1;
	localparam int DIMS_W     = DIM_IDX_W + 1;
	localparam int STORE_AW   = REP_IDX_W + DIM_IDX_W;
	localparam int STORE_DEPTH = MAX_REPS * MAX_DIMS;
	localparam int DIFF_W     = ELEM_WIDTH + 1;
	localparam int SQ_W       = 2 * ELEM_WIDTH;
	localparam int DIST_W     = 38;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = REP_CNT_W;

	localparam logic [CFG_IDX_W-1:0] CFG_REP_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DIMS      = 2'd1;

	localparam logic [REP_CNT_W-1:0] REP_COUNT_RESET = REP_CNT_W'(1);
	localparam logic [DIMS_W-1:0]    DIMS_RESET      = DIMS_W'(MAX_DIMS);

	localparam logic OP_REP_WRITE = 1'b0;
	localparam logic OP_QUERY     = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_FLUSH = 4'b0100,
		ST_PUSH  = 4'b1000
	} scan_state_t;

	// one issued read, follows the memory data down the pipeline
	typedef struct packed {
		logic                 valid;
		logic                 first_dim;
		logic                 last_dim;
		logic                 final_row;
		logic [REP_IDX_W-1:0] row;
	} scan_tag_t;

	typedef struct packed {
		scan_state_t state;
		logic        idle;
		logic        push;
	} ctrl_status_t;

endpackage

`default_nettype wire

FILE: src/nvl2s_item_if.sv
// ----------------------------------------------------------------------------
// nvl2s_item_if
// Input channel: table writes and query elements, valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface nvl2s_item_if;
	import nvl2s_pkg::*;

	logic                         valid;
	logic                         ready;
	logic                         opcode;
	logic [REP_IDX_W-1:0]         rep_index;
	logic [DIM_IDX_W-1:0]         dim_index;
	logic signed [ELEM_WIDTH-1:0] element_value;

	modport source (output valid, opcode, rep_index, dim_index, element_value, input ready);
	modport sink   (input valid, opcode, rep_index, dim_index, element_value, output ready);
endinterface

`default_nettype wire

FILE: src/nvl2s_result_if.sv
// ----------------------------------------------------------------------------
// nvl2s_result_if
// Output channel: nearest row and its squared distance, valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface nvl2s_result_if;
	import nvl2s_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [REP_IDX_W-1:0] match_index;
	logic [DIST_W-1:0]    match_distance;

	modport source (output valid, match_index, match_distance, input ready);
	modport sink   (input valid, match_index, match_distance, output ready);
endinterface

`default_nettype wire

FILE: src/nvl2s_ram.sv
// ----------------------------------------------------------------------------
// nvl2s_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nvl2s_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	localparam int AW   = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

FILE: src/nvl2s_ctrl.sv
// ----------------------------------------------------------------------------
// nvl2s_ctrl
// Scan sequencer: walks rows and dimensions, issues memory reads, hands off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nvl2s_ctrl import nvl2s_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic [REP_CNT_W-1:0] rep_count,
	input  wire logic [DIMS_W-1:0]    dims,
	input  wire logic                 query_acc,
	input  wire logic [DIM_IDX_W-1:0] query_dim,
	input  wire logic                 fin,
	input  wire logic                 push_ack,
	output logic      [STORE_AW-1:0]  rep_raddr,
	output logic      [DIM_IDX_W-1:0] query_raddr,
	output scan_tag_t                 tag_s1,
	output ctrl_status_t              status
);

	scan_state_t          state_q;
	logic [REP_IDX_W-1:0] row_q;
	logic [DIM_IDX_W-1:0] dim_q;
	logic [REP_IDX_W-1:0] last_row_q;
	logic [DIM_IDX_W-1:0] last_dim_q;
	logic [REP_IDX_W-1:0] last_row_c;
	logic [DIM_IDX_W-1:0] last_dim_c;
	logic                 start;
	logic                 issue;
	logic                 dim_end;
	logic                 row_end;

	// registers are saturated into their legal range, zero counts as one
	always_comb begin
		priority if (rep_count == '0) begin
			last_row_c = '0;
		end else if (rep_count > REP_CNT_W'(MAX_REPS)) begin
			last_row_c = REP_IDX_W'(MAX_REPS - 1);
		end else begin
			last_row_c = REP_IDX_W'(rep_count - REP_CNT_W'(1));
		end
		priority if (dims == '0) begin
			last_dim_c = '0;
		end else if (dims > DIMS_W'(MAX_DIMS)) begin
			last_dim_c = DIM_IDX_W'(MAX_DIMS - 1);
		end else begin
			last_dim_c = DIM_IDX_W'(dims - DIMS_W'(1));
		end
	end

	assign start       = (state_q == ST_IDLE) && query_acc && (query_dim == last_dim_c);
	assign issue       = (state_q == ST_SCAN);
	assign dim_end     = (dim_q == last_dim_q);
	assign row_end     = (row_q == last_row_q);
	assign rep_raddr   = {row_q, dim_q};
	assign query_raddr = dim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_q   <= '0;
			dim_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						row_q   <= '0;
						dim_q   <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (dim_end) begin
						dim_q <= '0;
						if (row_end) begin
							state_q <= ST_FLUSH;
						end else begin
							row_q <= row_q + REP_IDX_W'(1);
						end
					end else begin
						dim_q <= dim_q + DIM_IDX_W'(1);
					end
				end
				ST_FLUSH: begin
					if (fin) begin
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (push_ack) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			last_row_q <= last_row_c;
			last_dim_q <= last_dim_c;
		end
	end

	// tag lines up with the registered memory read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1.valid     <= issue;
			tag_s1.first_dim <= (dim_q == '0);
			tag_s1.last_dim  <= dim_end;
			tag_s1.final_row <= row_end;
			tag_s1.row       <= row_q;
		end
	end

	assign status.state = state_q;
	assign status.idle  = (state_q == ST_IDLE);
	assign status.push  = (state_q == ST_PUSH);

endmodule

`default_nettype wire

FILE: src/nvl2s_dist.sv
// ----------------------------------------------------------------------------
// nvl2s_dist
// Distance pipeline: difference, square, row accumulate, running minimum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nvl2s_dist import nvl2s_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  scan_tag_t                  tag_s1,
	input  wire logic [ELEM_WIDTH-1:0] query_rdata,
	input  wire logic [ELEM_WIDTH-1:0] rep_rdata,
	output logic      [REP_IDX_W-1:0]  best_index,
	output logic      [DIST_W-1:0]     best_distance,
	output logic                       fin
);

	scan_tag_t                tag_s2;
	scan_tag_t                tag_s3;
	logic signed [DIFF_W-1:0] diff_s2;
	logic signed [2*DIFF_W-1:0] prod;
	logic [SQ_W-1:0]          sq_s3;
	logic [DIST_W-1:0]        acc_q;
	logic [DIST_W-1:0]        sum_c;
	logic                     row_valid_s4;
	logic                     final_s4;
	logic [REP_IDX_W-1:0]     row_s4;
	logic [DIST_W-1:0]        dist_s4;
	logic [REP_IDX_W-1:0]     best_idx_q;
	logic [DIST_W-1:0]        best_dist_q;
	logic                     fin_q;

	assign prod  = diff_s2 * diff_s2;
	assign sum_c = (tag_s3.first_dim ? '0 : acc_q) + DIST_W'(sq_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2       <= '0;
			tag_s3       <= '0;
			row_valid_s4 <= 1'b0;
			fin_q        <= 1'b0;
		end else begin
			tag_s2       <= tag_s1;
			tag_s3       <= tag_s2;
			row_valid_s4 <= tag_s3.valid && tag_s3.last_dim;
			fin_q        <= row_valid_s4 && final_s4;
		end
	end

	always_ff @(posedge clk) begin
		diff_s2 <= $signed({query_rdata[ELEM_WIDTH-1], query_rdata})
			- $signed({rep_rdata[ELEM_WIDTH-1], rep_rdata});

		// square of a difference fits in SQ_W bits
		sq_s3 <= prod[SQ_W-1:0];

		if (tag_s3.valid) begin
			acc_q <= sum_c;
		end
		dist_s4  <= sum_c;
		row_s4   <= tag_s3.row;
		final_s4 <= tag_s3.final_row;

		// strict compare keeps the lowest row on ties
		if (row_valid_s4 && ((row_s4 == '0) || (dist_s4 < best_dist_q))) begin
			best_dist_q <= dist_s4;
			best_idx_q  <= row_s4;
		end
	end

	assign best_index    = best_idx_q;
	assign best_distance = best_dist_q;
	assign fin           = fin_q;

endmodule

`default_nettype wire

FILE: src/nearest_vector_l2_search_top.sv
// ----------------------------------------------------------------------------
// nearest_vector_l2_search_top
// Brute-force nearest representative by exact squared Euclidean distance.
// ----------------------------------------------------------------------------
// table writes and non-final query elements are accepted whenever the block is idle
// final query element: starts a scan over rep_count rows of dims elements, one store read per cycle,
//   followed by the pipeline drain and hand-off before the result is valid
// input is held off during a scan; one finished result may wait in the output register
// reset sets rep_count to 1 and dims to 64; store and query buffer are not cleared
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module nearest_vector_l2_search_top import nvl2s_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	nvl2s_item_if.sink                 item,
	nvl2s_result_if.source             result
);

	logic [REP_CNT_W-1:0]  rep_count_q;
	logic [DIMS_W-1:0]     dims_q;
	logic                  item_acc;
	logic                  rep_we;
	logic                  query_we;
	logic [STORE_AW-1:0]   rep_raddr;
	logic [DIM_IDX_W-1:0]  query_raddr;
	logic [ELEM_WIDTH-1:0] rep_rdata;
	logic [ELEM_WIDTH-1:0] query_rdata;
	scan_tag_t             tag_s1;
	ctrl_status_t          status;
	logic                  fin;
	logic                  push_ack;
	logic [REP_IDX_W-1:0]  best_index;
	logic [DIST_W-1:0]     best_distance;
	logic                  res_valid_q;
	logic [REP_IDX_W-1:0]  res_index_q;
	logic [DIST_W-1:0]     res_dist_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rep_count_q <= REP_COUNT_RESET;
			dims_q      <= DIMS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_REP_COUNT: begin
					rep_count_q <= cfg_wdata[REP_CNT_W-1:0];
				end
				CFG_DIMS: begin
					dims_q <= cfg_wdata[DIMS_W-1:0];
				end
				// spare indexes hold no register
				default: begin
				end
			endcase
		end
	end

	assign item.ready = status.idle;
	assign item_acc   = item.valid && item.ready;
	assign rep_we     = item_acc && (item.opcode == OP_REP_WRITE);
	assign query_we   = item_acc && (item.opcode == OP_QUERY);

	nvl2s_ram #(
		.WIDTH (ELEM_WIDTH),
		.DEPTH (STORE_DEPTH)
	) u_rep_store (
		.clk   (clk),
		.we    (rep_we),
		.waddr ({item.rep_index, item.dim_index}),
		.wdata (item.element_value),
		.raddr (rep_raddr),
		.rdata (rep_rdata)
	);

	nvl2s_ram #(
		.WIDTH (ELEM_WIDTH),
		.DEPTH (MAX_DIMS)
	) u_query_buf (
		.clk   (clk),
		.we    (query_we),
		.waddr (item.dim_index),
		.wdata (item.element_value),
		.raddr (query_raddr),
		.rdata (query_rdata)
	);

	nvl2s_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.rep_count   (rep_count_q),
		.dims        (dims_q),
		.query_acc   (query_we),
		.query_dim   (item.dim_index),
		.fin         (fin),
		.push_ack    (push_ack),
		.rep_raddr   (rep_raddr),
		.query_raddr (query_raddr),
		.tag_s1      (tag_s1),
		.status      (status)
	);

	nvl2s_dist u_dist (
		.clk           (clk),
		.arst_n        (arst_n),
		.tag_s1        (tag_s1),
		.query_rdata   (query_rdata),
		.rep_rdata     (rep_rdata),
		.best_index    (best_index),
		.best_distance (best_distance),
		.fin           (fin)
	);

	// result register frees the scan engine as soon as the slot is open
	assign push_ack = status.push && (!res_valid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (push_ack) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push_ack) begin
			res_index_q <= best_index;
			res_dist_q  <= best_distance;
		end
	end

	assign result.valid          = res_valid_q;
	assign result.match_index    = res_index_q;
	assign result.match_distance = res_dist_q;

	`NVL2S_ASSERT_IMPLIES(a_no_write_in_scan, rep_we, !tag_s1.valid && status.idle, "table write during scan")
	`NVL2S_ASSERT_IMPLIES(a_fin_in_flush, fin, status.state == ST_FLUSH, "scan finished outside flush")
	`NVL2S_ASSERT_IMPLIES(a_result_from_push, $rose(result.valid), $past(status.state) == ST_PUSH, "result without scan")
	`NVL2S_ASSERT_NEXT(a_push_to_idle, push_ack, status.idle && result.valid, "hand-off did not complete")

endmodule

`default_nettype wire
